/* rtl/core/ehc_pkg.sv */
// Shared types, codes and bit-placement functions of the SEC-DED codec.
`timescale 1ns / 1ps

package ehc_pkg;

  localparam int MAX_ORDER = 6;
  localparam int MIN_ORDER = 3;
  localparam int CW_W      = 1 << MAX_ORDER;
  localparam int DATA_W    = CW_W - MAX_ORDER - 1;
  localparam int SYN_W     = MAX_ORDER;
  localparam int ORDER_W   = 3;
  localparam int CNT_W     = 32;

  localparam logic [1:0] MODE_ENCODE = 2'd0;
  localparam logic [1:0] MODE_DECODE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CORRECTED = 2'd1;
  localparam logic [1:0] STATUS_DOUBLE    = 2'd2;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]        mode;
    logic [CW_W-1:0]   word;
    logic [SYN_W-1:0]  syn;
    logic              par;
  } ehc_item_t;

  function automatic logic is_pow2(input int x);
    return (x != 0) && ((x & (x - 1)) == 0);
  endfunction

  // Places data bit j (0-based) at the (j+1)-th position (1-based) that is not a power of two.
  function automatic logic [CW_W-1:0] scatter_data(input logic [DATA_W-1:0] d);
    logic [CW_W-1:0] cw;
    int              j;
    cw = '0;
    j  = 0;
    for (int i = 1; i < CW_W; i++) begin
      if (!is_pow2(i)) begin
        cw[i-1] = d[j];
        j++;
      end
    end
    return cw;
  endfunction

  function automatic logic [DATA_W-1:0] extract_data(input logic [CW_W-1:0] cw);
    logic [DATA_W-1:0] d;
    int                j;
    d = '0;
    j = 0;
    for (int i = 1; i < CW_W; i++) begin
      if (!is_pow2(i)) begin
        d[j] = cw[i-1];
        j++;
      end
    end
    return d;
  endfunction

  // Positions 1..CW_W-1 whose index has bit b set.
  function automatic logic [CW_W-1:0] syn_mask(input int b);
    logic [CW_W-1:0] msk;
    msk = '0;
    for (int i = 1; i < CW_W; i++) begin
      msk[i-1] = ((i >> b) & 1) != 0;
    end
    return msk;
  endfunction

  function automatic logic [CW_W-1:0] len_mask(input logic [ORDER_W-1:0] m);
    logic [CW_W-1:0] msk;
    case (m)
      3'd3:    msk = 64'h0000_0000_0000_00FF;
      3'd4:    msk = 64'h0000_0000_0000_FFFF;
      3'd5:    msk = 64'h0000_0000_FFFF_FFFF;
      default: msk = '1;
    endcase
    return msk;
  endfunction

  // n-1 for n = 2^m; also the mask of the low m syndrome bits.
  function automatic logic [SYN_W-1:0] last_pos(input logic [ORDER_W-1:0] m);
    logic [SYN_W:0] full;
    full = (SYN_W+1)'(1) << m;
    return SYN_W'(full - (SYN_W+1)'(1));
  endfunction

endpackage

/* rtl/core/ehc_front.sv */
// Front part: places data bits or masks the received word and forms syndrome and parity.
`timescale 1ns / 1ps

module ehc_front (
  input  logic [1:0]                  mode,
  input  logic [ehc_pkg::DATA_W-1:0]  data_bits,
  input  logic [ehc_pkg::CW_W-1:0]    codeword_in,
  input  logic [ehc_pkg::ORDER_W-1:0] order,
  output ehc_pkg::ehc_item_t          item
);
  import ehc_pkg::*;

  logic [CW_W-1:0]  word;
  logic [SYN_W-1:0] syn_raw;

  always_comb begin
    if (mode == MODE_ENCODE) begin
      word = scatter_data(data_bits) & len_mask(order);
    end else begin
      word = codeword_in & len_mask(order);
    end
    // Bit CW_W-1 never enters the syndrome; below full length the last bit
    // lands on syndrome bit m, which the length mask drops.
    for (int b = 0; b < SYN_W; b++) begin
      syn_raw[b] = ^(word & syn_mask(b));
    end
  end

  assign item.mode = mode;
  assign item.word = word;
  assign item.syn  = syn_raw & last_pos(order);
  assign item.par  = ^word;

endmodule

/* rtl/core/ehc_queue.sv */
// Two-entry item queue between the front and back parts.
`timescale 1ns / 1ps

module ehc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ehc_pkg::ehc_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output ehc_pkg::ehc_item_t head_item
);
  import ehc_pkg::*;

  ehc_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/core/ehc_back.sv */
// Back part: parity insertion, single-error correction, data extraction and counters.
`timescale 1ns / 1ps

module ehc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ehc_pkg::ORDER_W-1:0] order,
  input  logic                        q_not_empty,
  input  ehc_pkg::ehc_item_t          q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ehc_pkg::CW_W-1:0]    codeword_out,
  output logic [ehc_pkg::DATA_W-1:0]  data_out,
  output logic [1:0]                  status,
  output logic [ehc_pkg::SYN_W-1:0]   error_position,
  output logic [ehc_pkg::CNT_W-1:0]   corrected_count,
  output logic [ehc_pkg::CNT_W-1:0]   uncorrectable_count,
  output logic [ehc_pkg::CNT_W-1:0]   encoded_count,
  output logic [ehc_pkg::CNT_W-1:0]   decoded_count
);
  import ehc_pkg::*;

  logic              valid_r, valid_nxt;
  logic [CW_W-1:0]   cw_r, cw_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [SYN_W-1:0]  epos_r, epos_nxt;
  logic [CNT_W-1:0]  corr_r, corr_nxt;
  logic [CNT_W-1:0]  unc_r, unc_nxt;
  logic [CNT_W-1:0]  enc_r, enc_nxt;
  logic [CNT_W-1:0]  dec_r, dec_nxt;

  logic [SYN_W-1:0]  nm1;
  logic [CW_W-1:0]   enc_word;
  logic [CW_W-1:0]   dec_word;

  assign q_pop = q_not_empty && (!valid_r || out_ready);
  assign nm1   = last_pos(order);

  always_comb begin
    // Encode: the syndrome of the placed data gives the check bits directly.
    enc_word = q_item.word;
    for (int p = 0; p < SYN_W; p++) begin
      enc_word[(1 << p) - 1] = q_item.syn[p];
    end
    enc_word[nm1] = q_item.par ^ (^q_item.syn);

    valid_nxt  = valid_r && !out_ready;
    cw_nxt     = cw_r;
    data_nxt   = data_r;
    status_nxt = status_r;
    epos_nxt   = epos_r;
    corr_nxt   = corr_r;
    unc_nxt    = unc_r;
    enc_nxt    = enc_r;
    dec_nxt    = dec_r;
    dec_word   = q_item.word;

    if (q_pop) begin
      valid_nxt  = 1'b1;
      cw_nxt     = '0;
      data_nxt   = '0;
      status_nxt = STATUS_OK;
      epos_nxt   = '0;
      case (q_item.mode)
        MODE_ENCODE: begin
          cw_nxt  = enc_word;
          enc_nxt = enc_r + CNT_W'(1);
        end
        MODE_DECODE: begin
          dec_nxt = dec_r + CNT_W'(1);
          if (q_item.par) begin
            // Odd overall parity: one flipped bit; a zero syndrome points at
            // the overall-parity bit itself.
            epos_nxt   = (q_item.syn != '0) ? q_item.syn - SYN_W'(1) : nm1;
            dec_word   = q_item.word ^ (CW_W'(1) << epos_nxt);
            status_nxt = STATUS_CORRECTED;
            corr_nxt   = corr_r + CNT_W'(1);
            cw_nxt     = dec_word;
            data_nxt   = extract_data(dec_word);
          end else if (q_item.syn != '0) begin
            status_nxt = STATUS_DOUBLE;
            unc_nxt    = unc_r + CNT_W'(1);
            cw_nxt     = q_item.word;
          end else begin
            cw_nxt   = q_item.word;
            data_nxt = extract_data(q_item.word);
          end
        end
        MODE_CLEAR: begin
          corr_nxt = '0;
          unc_nxt  = '0;
          enc_nxt  = '0;
          dec_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      corr_r  <= '0;
      unc_r   <= '0;
      enc_r   <= '0;
      dec_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      corr_r  <= corr_nxt;
      unc_r   <= unc_nxt;
      enc_r   <= enc_nxt;
      dec_r   <= dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cw_r     <= cw_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
    epos_r   <= epos_nxt;
  end

  assign out_valid           = valid_r;
  assign codeword_out        = cw_r;
  assign data_out            = data_r;
  assign status              = status_r;
  assign error_position      = epos_r;
  assign corrected_count     = corr_r;
  assign uncorrectable_count = unc_r;
  assign encoded_count       = enc_r;
  assign decoded_count       = dec_r;

endmodule

/* rtl/core/extended_hamming_secded_codec.sv */
// Top level of the extended Hamming SEC-DED codec: order register, front, queue and back.
//
// Channel   Direction  Handshake              Carries
// in_       input      in_valid / in_ready    mode, data bits, received codeword
// out_      output     out_valid / out_ready  codeword, data, status, position, counters
// cfg_      input      cfg_valid / cfg_ready  code order m (codeword of 2^m bits)
//
// One item is taken per cycle while in_ready is high; the back part pops a queued item
// when its output register is empty or being drained and loads the result into it.
// Reset (synchronous, active low) empties the queue and output register, zeroes the
// four counters and sets the code order to 3. A stalled output fills the two-entry
// queue; in_ready falls only when it is full. The configuration port is always ready;
// the user must see that it is written only while the block is idle, which the block
// itself does not enforce.
`timescale 1ns / 1ps

module extended_hamming_secded_codec (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ehc_pkg::ORDER_W-1:0] cfg_code_order,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_mode,
  input  logic [ehc_pkg::DATA_W-1:0]  in_data_bits,
  input  logic [ehc_pkg::CW_W-1:0]    in_codeword_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ehc_pkg::CW_W-1:0]    out_codeword_out,
  output logic [ehc_pkg::DATA_W-1:0]  out_data_out,
  output logic [1:0]                  out_status,
  output logic [ehc_pkg::SYN_W-1:0]   out_error_position,
  output logic [ehc_pkg::CNT_W-1:0]   out_corrected_count,
  output logic [ehc_pkg::CNT_W-1:0]   out_uncorrectable_count,
  output logic [ehc_pkg::CNT_W-1:0]   out_encoded_count,
  output logic [ehc_pkg::CNT_W-1:0]   out_decoded_count
);
  import ehc_pkg::*;

  logic [ORDER_W-1:0] order_r, order_nxt;
  logic [ORDER_W-1:0] eff_order;
  ehc_item_t          front_item;
  ehc_item_t          head_item;
  logic               q_full;
  logic               q_not_empty;
  logic               q_pop;
  logic               push;

  // The order register holds the raw written value; the effective order is
  // clamped into the supported range of orders three to MAX_ORDER.
  assign cfg_ready = 1'b1;
  assign order_nxt = (cfg_valid && cfg_ready) ? cfg_code_order : order_r;

  always_comb begin
    if (order_r < ORDER_W'(MIN_ORDER)) begin
      eff_order = ORDER_W'(MIN_ORDER);
    end else if (order_r > ORDER_W'(MAX_ORDER)) begin
      eff_order = ORDER_W'(MAX_ORDER);
    end else begin
      eff_order = order_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_W'(MIN_ORDER);
    end else begin
      order_r <= order_nxt;
    end
  end

  // Front part works straight off the input ports, so an accepted item is
  // already classified when it is written into the queue.
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  ehc_front u_front (
    .mode        (in_mode),
    .data_bits   (in_data_bits),
    .codeword_in (in_codeword_in),
    .order       (eff_order),
    .item        (front_item)
  );

  ehc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  // Back part pops whenever its output register is empty or being drained.
  ehc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .order               (eff_order),
    .q_not_empty         (q_not_empty),
    .q_item              (head_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .codeword_out        (out_codeword_out),
    .data_out            (out_data_out),
    .status              (out_status),
    .error_position      (out_error_position),
    .corrected_count     (out_corrected_count),
    .uncorrectable_count (out_uncorrectable_count),
    .encoded_count       (out_encoded_count),
    .decoded_count       (out_decoded_count)
  );

endmodule
